>>> hdl/cscan_disk_request_scheduler_unit_defines.svh
// assertion macros shared by the scheduler modules
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define CDRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/cdrs_pkg.sv
package cdrs_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int TRK_W = 16;
	localparam int SEEK_W = 18;
	localparam logic [TRK_W-1:0] LAST_TRACK_RST = 16'd4999;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_RUN  = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [TRK_W-1:0]   value;
	} in_item_t;

	typedef struct packed {
		logic [TRK_W-1:0]   served_track;
		logic               served_valid;
		logic [SEEK_W-1:0]  total_seek;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic take;
		logic wrap;
		logic finish;
		logic wrap_charge;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic any;
		logic at_last;
		logic hold_valid;
		logic out_free;
	} dp_sts_t;

endpackage

>>> hdl/cdrs_dpath.sv
`include "cscan_disk_request_scheduler_unit_defines.svh"

module cdrs_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [cdrs_pkg::TRK_W-1:0]  cfg_wr_data,
	input  cdrs_pkg::in_item_t          in_item,
	input  cdrs_pkg::dp_cmd_t           cmd,
	output cdrs_pkg::dp_sts_t           sts,
	output cdrs_pkg::out_item_t         out_data,
	output logic                        out_valid,
	input  logic                        out_ready
);
	import cdrs_pkg::*;

	logic [TRK_W-1:0]       last_track_q;
	logic [TRK_W-1:0]       trk_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]       idx_q;
	logic [TRK_W-1:0]       best_q;
	logic                   found_q;
	logic                   any_q;
	logic [TRK_W-1:0]       floor_q;
	logic [TRK_W-1:0]       head_q;
	logic [SEEK_W-1:0]      seek_q;
	out_item_t              hold_q;
	logic                   hold_valid_q;
	out_item_t              out_q;
	logic                   out_valid_q;

	logic                   free_hit;
	logic [IDX_W-1:0]       free_idx;
	logic [TRK_W-1:0]       cur_trk;
	logic                   cur_live;
	logic                   cur_elig;
	logic                   at_last;
	logic                   out_free;
	logic [TRK_W-1:0]       start_head;
	logic [SEEK_W-1:0]      take_seek;
	logic [SEEK_W-1:0]      wrap_seek;
	logic [QUEUE_DEPTH-1:0] match_best;

	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_hit = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match_best[i] = (trk_q[i] == best_q);
		end
	end

	assign cur_trk    = trk_q[idx_q];
	assign cur_live   = valid_q[idx_q] && (cur_trk <= last_track_q);
	assign cur_elig   = cur_live && (cur_trk >= floor_q);
	assign at_last    = (best_q == last_track_q);
	assign out_free   = !out_valid_q || out_ready;
	assign start_head = (in_item.value > last_track_q) ? last_track_q : in_item.value;

	assign take_seek = seek_q + SEEK_W'(best_q - head_q)
		+ ((cmd.wrap_charge && at_last) ? SEEK_W'(last_track_q) : SEEK_W'(0));
	assign wrap_seek = seek_q + SEEK_W'(last_track_q - head_q) + SEEK_W'(last_track_q);

	assign sts.scan_done  = (idx_q == IDX_W'(QUEUE_DEPTH - 1));
	assign sts.found      = found_q;
	assign sts.any        = any_q;
	assign sts.at_last    = at_last;
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = out_free;

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_track_q <= LAST_TRACK_RST;
			valid_q      <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			any_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				last_track_q <= cfg_wr_data;
			end
			if (cmd.load && free_hit) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.scan) begin
				idx_q <= sts.scan_done ? '0 : idx_q + IDX_W'(1);
				if (cur_live) begin
					any_q <= 1'b1;
				end
				if (cur_elig && (!found_q || cur_trk < best_q)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.start || cmd.take || cmd.wrap || cmd.finish) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				any_q   <= 1'b0;
			end
			if (cmd.start) begin
				hold_valid_q <= 1'b0;
			end
			if (cmd.take) begin
				hold_valid_q <= 1'b1;
				valid_q      <= valid_q & ~match_best;
			end
			if (cmd.finish) begin
				hold_valid_q <= 1'b0;
				valid_q      <= '0;
			end
			if ((cmd.take && hold_valid_q) || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load && free_hit) begin
			trk_q[free_idx] <= in_item.value;
		end
		if (cmd.scan && cur_elig && (!found_q || cur_trk < best_q)) begin
			best_q <= cur_trk;
		end
		if (cmd.start) begin
			head_q  <= start_head;
			floor_q <= start_head;
			seek_q  <= '0;
		end
		if (cmd.take) begin
			if (hold_valid_q) begin
				out_q <= hold_q;
			end
			hold_q.served_track <= best_q;
			hold_q.served_valid <= 1'b1;
			hold_q.total_seek   <= take_seek;
			hold_q.last         <= 1'b0;
			seek_q              <= take_seek;
			if (cmd.wrap_charge && at_last) begin
				head_q  <= '0;
				floor_q <= '0;
			end else begin
				head_q  <= best_q;
				floor_q <= best_q + TRK_W'(1);
			end
		end
		if (cmd.wrap) begin
			seek_q  <= wrap_seek;
			head_q  <= '0;
			floor_q <= '0;
		end
		if (cmd.finish) begin
			if (hold_valid_q) begin
				out_q.served_track <= hold_q.served_track;
				out_q.served_valid <= 1'b1;
				out_q.total_seek   <= hold_q.total_seek;
			end else begin
				out_q.served_track <= '0;
				out_q.served_valid <= 1'b0;
				out_q.total_seek   <= '0;
			end
			out_q.last <= 1'b1;
		end
	end

	`CDRS_ASSERT_IMP(a_take_room, cmd.take && hold_valid_q, out_free,
		"held result moved into a busy output register")
	`CDRS_ASSERT_NXT(a_queue_empty, cmd.finish, valid_q == '0,
		"queue not empty after a run")
	`CDRS_ASSERT_IMP(a_best_range, found_q, (best_q >= floor_q) && (best_q <= last_track_q),
		"candidate track outside the sweep window")

endmodule

>>> hdl/cdrs_ctrl.sv
`include "cscan_disk_request_scheduler_unit_defines.svh"

module cdrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdrs_pkg::action_t   in_action,
	input  cdrs_pkg::dp_sts_t   sts,
	output cdrs_pkg::dp_cmd_t   cmd
);
	import cdrs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;
	logic   phase_q;

	always_comb begin
		cmd             = '0;
		cmd.wrap_charge = !phase_q;
		in_ready        = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_action == ACT_RUN) begin
						cmd.start = 1'b1;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_DECIDE: begin
				if (sts.found) begin
					if (!sts.hold_valid || sts.out_free) begin
						cmd.take = 1'b1;
					end
				end else if (!phase_q && sts.any) begin
					cmd.wrap = 1'b1;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
				end
			end
			default: begin
				cmd.scan = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SCAN;
						phase_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (cmd.take) begin
						state_q <= ST_SCAN;
						if (!phase_q && sts.at_last) begin
							phase_q <= 1'b1;
						end
					end else if (cmd.wrap) begin
						state_q <= ST_SCAN;
						phase_q <= 1'b1;
					end else if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CDRS_ASSERT_IMP(a_one_cmd, 1'b1,
		$onehot0({cmd.load, cmd.start, cmd.scan, cmd.take, cmd.wrap, cmd.finish}),
		"more than one datapath command at once")
	`CDRS_ASSERT_NXT(a_finish_idle, cmd.finish, in_ready,
		"not ready for a new transfer after a run")

endmodule

>>> hdl/cscan_disk_request_scheduler_unit.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data   (action, value)
// out       output     out_valid / out_ready out_data  (served_track, served_valid,
//                                                       total_seek, last)
// cfg       input      cfg_wr_en             cfg_wr_data (last_track)
//
// a load fills a free queue entry and is dropped when the queue is full; a run starts,
// then scans the queue once per served track and once more for each empty sweep pass
// (one or two), the last of which closes the run
// the queue scan looks at one entry a cycle
// reset clears the queue valid bits and the output valid flag, and sets last_track to 4999
// results leave through an output register; a served track is held back one step so
// the final one can be marked, and the run stalls while out_ready holds it back
module cscan_disk_request_scheduler_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [cdrs_pkg::TRK_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cdrs_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cdrs_pkg::out_item_t         out_data
);
	import cdrs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	cdrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_action (in_data.action),
		.sts       (sts),
		.cmd       (cmd)
	);

	cdrs_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_data    (out_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule
